/* hw/rtl/png_scanline_unfilter_core_defines.svh */
// Assertion macros used by the scanline unfilter back end.
`ifndef PNG_SCANLINE_UNFILTER_CORE_DEFINES_SVH
`define PNG_SCANLINE_UNFILTER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define UF_ASSERT_NOW(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define UF_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* hw/rtl/png_uf_pkg.sv */
// Shared constants, item type and filter arithmetic of the scanline unfilter.
package png_uf_pkg;

  localparam int DEFAULT_MAX_ROW_BYTES = 2048;
  localparam int DEFAULT_MAX_ROWS      = 512;
  localparam int QUEUE_DEPTH           = 4;

  // Configuration register indexes
  localparam logic [1:0] CFG_BYTES_PER_PIXEL = 2'd0;
  localparam logic [1:0] CFG_ROW_BYTES       = 2'd1;
  localparam logic [1:0] CFG_IMAGE_ROWS      = 2'd2;

  // Filter type codes
  localparam logic [2:0] FILT_NONE    = 3'd0;
  localparam logic [2:0] FILT_SUB     = 3'd1;
  localparam logic [2:0] FILT_UP      = 3'd2;
  localparam logic [2:0] FILT_AVERAGE = 3'd3;
  localparam logic [2:0] FILT_PAETH   = 3'd4;

  // One classified byte on its way from the front to the back
  typedef struct packed {
    logic [7:0] raw;
    logic [2:0] kind;
    logic [1:0] left_sel;   // bytes per pixel minus one
    logic       first_row;
    logic       has_left;
    logic       end_row;
    logic       end_image;
    logic       bad;
  } uf_item_t;

  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic signed [10:0] p;
    logic signed [10:0] da;
    logic signed [10:0] db;
    logic signed [10:0] dc;
    logic [10:0] pa;
    logic [10:0] pb;
    logic [10:0] pc;
    p  = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({3'b000, c});
    da = p - $signed({3'b000, a});
    db = p - $signed({3'b000, b});
    dc = p - $signed({3'b000, c});
    pa = (da < 0) ? 11'(-da) : 11'(da);
    pb = (db < 0) ? 11'(-db) : 11'(db);
    pc = (dc < 0) ? 11'(-dc) : 11'(dc);
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end
    return c;
  endfunction

  function automatic logic [7:0] average(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8:1];
  endfunction

endpackage

/* hw/rtl/png_uf_front.sv */
// Front end: configuration registers, filter byte parsing, row and column tracking.
module png_uf_front #(
  parameter int MAX_ROW_BYTES = png_uf_pkg::DEFAULT_MAX_ROW_BYTES,
  parameter int MAX_ROWS      = png_uf_pkg::DEFAULT_MAX_ROWS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [11:0]                      cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_byte,
  input  logic                             q_full,
  output logic                             push,
  output png_uf_pkg::uf_item_t             push_item,
  output logic [$clog2(MAX_ROW_BYTES)-1:0] push_col
);

  localparam int AW = $clog2(MAX_ROW_BYTES);
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [2:0]    bytes_per_pixel;
  logic [11:0]   row_bytes;
  logic [9:0]    image_rows;
  logic [AW-1:0] column_count;
  logic [RW-1:0] row_count;
  logic [2:0]    filter_kind;
  logic          expect_filter_byte;
  logic          halted;

  logic [2:0]  bpp;
  logic [31:0] len;
  logic [31:0] rows;
  logic        accept;
  logic        is_bad;
  logic        end_row;
  logic        end_image;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= 3'd4;
      row_bytes       <= 12'd1;
      image_rows      <= 10'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        png_uf_pkg::CFG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg_wdata[2:0];
        png_uf_pkg::CFG_ROW_BYTES:       row_bytes       <= cfg_wdata;
        png_uf_pkg::CFG_IMAGE_ROWS:      image_rows      <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // clamp the registers into their working ranges
  always_comb begin
    if (bytes_per_pixel == 3'd0) begin
      bpp = 3'd1;
    end else if (bytes_per_pixel > 3'd4) begin
      bpp = 3'd4;
    end else begin
      bpp = bytes_per_pixel;
    end
    if (row_bytes == 12'd0) begin
      len = 32'd1;
    end else if (32'(row_bytes) > 32'(MAX_ROW_BYTES)) begin
      len = 32'(MAX_ROW_BYTES);
    end else begin
      len = 32'(row_bytes);
    end
    if (image_rows == 10'd0) begin
      rows = 32'd1;
    end else if (32'(image_rows) > 32'(MAX_ROWS)) begin
      rows = 32'(MAX_ROWS);
    end else begin
      rows = 32'(image_rows);
    end
  end

  assign in_ready  = halted || !q_full;
  assign accept    = in_valid && in_ready;
  assign is_bad    = in_byte > {5'd0, png_uf_pkg::FILT_PAETH};
  assign end_row   = (32'(column_count) + 32'd1) >= len;
  assign end_image = end_row && ((32'(row_count) + 32'd1) >= rows);

  assign push = accept && !halted && (!expect_filter_byte || is_bad);

  always_comb begin
    push_item           = '0;
    push_item.raw       = in_byte;
    push_item.kind      = filter_kind;
    push_item.left_sel  = 2'(bpp - 3'd1);
    push_item.first_row = (row_count == '0);
    push_item.has_left  = 32'(column_count) >= 32'(bpp);
    push_item.end_row   = end_row;
    push_item.end_image = end_image;
    push_item.bad       = expect_filter_byte;
  end
  assign push_col = column_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count       <= '0;
      row_count          <= '0;
      filter_kind        <= png_uf_pkg::FILT_NONE;
      expect_filter_byte <= 1'b1;
      halted             <= 1'b0;
    end else if (accept && !halted) begin
      if (expect_filter_byte) begin
        if (is_bad) begin
          halted <= 1'b1;
        end else begin
          filter_kind        <= in_byte[2:0];
          expect_filter_byte <= 1'b0;
          column_count       <= '0;
        end
      end else if (end_row) begin
        expect_filter_byte <= 1'b1;
        column_count       <= '0;
        row_count          <= end_image ? '0 : RW'(row_count + 1'b1);
      end else begin
        column_count <= AW'(column_count + 1'b1);
      end
    end
  end

endmodule

/* hw/rtl/png_uf_queue.sv */
// Short FIFO of classified bytes between front and back.
module png_uf_queue #(
  parameter int AW = 11
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  png_uf_pkg::uf_item_t push_item,
  input  logic [AW-1:0]        push_col,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output png_uf_pkg::uf_item_t head_item,
  output logic [AW-1:0]        head_col
);

  localparam int DEPTH = png_uf_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  png_uf_pkg::uf_item_t items [DEPTH];
  logic [AW-1:0]        cols  [DEPTH];
  logic [PW-1:0]        wr_ptr;
  logic [PW-1:0]        rd_ptr;
  logic [CW-1:0]        count;
  logic                 do_push;
  logic                 do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = items[rd_ptr];
  assign head_col   = cols[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      items[wr_ptr] <= push_item;
      cols[wr_ptr]  <= push_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= PW'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= PW'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= CW'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

endmodule

/* hw/rtl/png_uf_back.sv */
// Back end: line store, byte reconstruction and output register.
`include "png_scanline_unfilter_core_defines.svh"

module png_uf_back #(
  parameter int MAX_ROW_BYTES = png_uf_pkg::DEFAULT_MAX_ROW_BYTES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  input  png_uf_pkg::uf_item_t             q_item,
  input  logic [$clog2(MAX_ROW_BYTES)-1:0] q_col,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_pixel,
  output logic                             out_row_last,
  output logic                             out_image_last,
  output logic                             out_bad
);

  localparam int AW = $clog2(MAX_ROW_BYTES);

  logic [7:0] line_mem [MAX_ROW_BYTES];

  logic                 r_valid;
  png_uf_pkg::uf_item_t r_item;
  logic [AW-1:0]        r_col;
  logic [7:0]           rdata;
  logic                 byp;
  logic [7:0]           byp_data;
  logic [31:0]          left_bytes;
  logic [31:0]          upper_left_bytes;

  logic       r_adv;
  logic       wr_en;
  logic [7:0] a;
  logic [7:0] b;
  logic [7:0] c;
  logic [7:0] v;

  assign r_adv = r_valid && (!out_valid || out_ready);
  assign pop   = q_valid && (!r_valid || r_adv);
  assign wr_en = r_adv && !r_item.bad;

  // above byte comes from the store, or straight from a same-cycle write
  always_comb begin
    b = r_item.first_row ? 8'd0 : (byp ? byp_data : rdata);
    a = r_item.has_left ? left_bytes[{r_item.left_sel, 3'b000} +: 8] : 8'd0;
    c = (r_item.has_left && !r_item.first_row) ?
        upper_left_bytes[{r_item.left_sel, 3'b000} +: 8] : 8'd0;
    unique case (r_item.kind)
      png_uf_pkg::FILT_SUB:     v = r_item.raw + a;
      png_uf_pkg::FILT_UP:      v = r_item.raw + b;
      png_uf_pkg::FILT_AVERAGE: v = r_item.raw + png_uf_pkg::average(a, b);
      png_uf_pkg::FILT_PAETH:   v = r_item.raw + png_uf_pkg::paeth_pick(a, b, c);
      default:                  v = r_item.raw;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[r_col] <= v;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rdata    <= line_mem[q_col];
      byp      <= wr_en && (r_col == q_col);
      byp_data <= v;
      r_item   <= q_item;
      r_col    <= q_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid          <= 1'b0;
      left_bytes       <= '0;
      upper_left_bytes <= '0;
    end else begin
      if (pop) begin
        r_valid <= 1'b1;
      end else if (r_adv) begin
        r_valid <= 1'b0;
      end
      if (wr_en) begin
        left_bytes       <= {left_bytes[23:0], v};
        upper_left_bytes <= {upper_left_bytes[23:0], b};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (r_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (r_adv) begin
      out_pixel      <= r_item.bad ? 8'd0 : v;
      out_row_last   <= !r_item.bad && r_item.end_row;
      out_image_last <= !r_item.bad && r_item.end_image;
      out_bad        <= r_item.bad;
    end
  end

  `UF_ASSERT_NOW(a_bad_clean, clk, rst, out_valid && out_bad, out_pixel == 8'd0 && !out_row_last && !out_image_last)
  `UF_ASSERT_NOW(a_image_ends_row, clk, rst, out_valid && out_image_last, out_row_last)
  `UF_ASSERT_NEXT(a_stage_holds, clk, rst, r_valid && !r_adv, r_valid && $stable(r_col) && $stable(r_item))

endmodule

/* hw/rtl/png_scanline_unfilter_core.sv */
// Top level of the PNG scanline unfilter (None, Sub, Up, Average, Paeth).
//
//   Channel  Direction  Signals                     Carries
//   s_*      in         s_tvalid s_tready s_tdata   raw_byte: filter type or filtered byte
//   m_*      out        m_tvalid m_tready m_tdata   pixel_byte, row_last, image_last, bad_filter
//                       m_tlast m_tuser
//   cfg_*    in         cfg_we cfg_index cfg_wdata  bytes_per_pixel, row_bytes, image_rows
//
// Throughput is one byte per cycle while m_* does not stall, filter type bytes included;
// a valid filter byte takes its cycle but produces no transfer on m_*. The figure is set
// by the loop in the back end from a reconstructed byte, through left_bytes, to the left
// neighbour of the next one (Sub, Average, Paeth). With no stall a byte passes the queue,
// the back end's stage register and the output register before m_tvalid rises.
// Reset (rst, synchronous) empties the queue and output register and restores the
// register defaults; the line store needs no clearing, every row writes before the next
// row reads. A stall on m_* backs up into the four-entry queue before s_tready drops.
module png_scanline_unfilter_core #(
  parameter int MAX_ROW_BYTES = png_uf_pkg::DEFAULT_MAX_ROW_BYTES,
  parameter int MAX_ROWS      = png_uf_pkg::DEFAULT_MAX_ROWS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] raw_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // [7:0] pixel_byte
  output logic        m_tlast,    // row_last
  output logic [1:0]  m_tuser,    // [0] image_last, [1] bad_filter
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_ROW_BYTES);

  logic                 push;
  png_uf_pkg::uf_item_t push_item;
  logic [AW-1:0]        push_col;
  logic                 q_full;
  logic                 pop;
  logic                 q_valid;
  png_uf_pkg::uf_item_t q_item;
  logic [AW-1:0]        q_col;
  logic                 image_last;
  logic                 bad_filter;

  // Front: parse filter bytes, track row and column, classify each data byte.
  // Once a bad filter type has been flagged, keep taking bytes and drop them.
  png_uf_front #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES),
    .MAX_ROWS      (MAX_ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item),
    .push_col  (push_col)
  );

  // Queue: decouple the input side from output back-pressure.
  png_uf_queue #(
    .AW (AW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .push_col   (push_col),
    .full       (q_full),
    .pop        (pop),
    .head_valid (q_valid),
    .head_item  (q_item),
    .head_col   (q_col)
  );

  // Back: read the above byte, reconstruct, write the line store, register the result.
  png_uf_back #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_col          (q_col),
    .pop            (pop),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_pixel      (m_tdata),
    .out_row_last   (m_tlast),
    .out_image_last (image_last),
    .out_bad        (bad_filter)
  );

  assign m_tuser = {bad_filter, image_last};

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for png_scanline_unfilter_core: directed table, random rows and a predictor.
module tb_top;

  localparam int LINE_MAX      = png_uf_pkg::DEFAULT_MAX_ROW_BYTES;
  localparam int ROWS_MAX      = png_uf_pkg::DEFAULT_MAX_ROWS;
  localparam int SETTLE_CYCLES = 12;     // pipeline is three deep, allow a margin
  localparam int STALL_LIMIT   = 2000;   // well above the longest receiver hold-off
  localparam int RANDOM_ITEMS  = 640;
  localparam int HOLD_CYCLES   = 400;

  // Receiver pacing modes
  localparam int RX_FREE   = 0;
  localparam int RX_SPARSE = 1;
  localparam int RX_COMB   = 2;
  localparam int RX_COIN   = 3;
  localparam int RX_HOLD   = 4;

  // One reconstructed byte as it leaves the block
  typedef struct packed {
    logic [7:0] pixel;
    logic       row_end;
    logic       img_end;
    logic       bad;
  } px_result_t;

  // Directed table: plain feed (predicted), feed with a typed result, feed that must give
  // nothing, and register write
  typedef enum logic [1:0] {OP_FEED, OP_FEED_SEEN, OP_FEED_SILENT, OP_WRITE} plan_op_t;

  typedef struct packed {
    plan_op_t    op;
    logic [1:0]  reg_sel;
    logic [11:0] value;    // register value, or the raw byte of a feed row
    px_result_t  want;
  } plan_row_t;

  localparam int PLAN_LEN = 30;
  localparam plan_row_t PLAN [0:PLAN_LEN-1] = '{
    // After reset one byte makes a row and one row an image, so every filter passes the
    // byte straight through with both end flags raised
    '{OP_FEED_SILENT, 2'b00, 12'(png_uf_pkg::FILT_NONE),    '0},
    '{OP_FEED_SEEN,   2'b00, 12'h000,                       '{8'h00, 1'b1, 1'b1, 1'b0}},
    '{OP_FEED_SILENT, 2'b00, 12'(png_uf_pkg::FILT_SUB),     '0},
    '{OP_FEED_SEEN,   2'b00, 12'h0FF,                       '{8'hFF, 1'b1, 1'b1, 1'b0}},
    '{OP_FEED_SILENT, 2'b00, 12'(png_uf_pkg::FILT_UP),      '0},
    '{OP_FEED_SEEN,   2'b00, 12'h080,                       '{8'h80, 1'b1, 1'b1, 1'b0}},
    '{OP_FEED_SILENT, 2'b00, 12'(png_uf_pkg::FILT_AVERAGE), '0},
    '{OP_FEED_SEEN,   2'b00, 12'h07F,                       '{8'h7F, 1'b1, 1'b1, 1'b0}},
    '{OP_FEED_SILENT, 2'b00, 12'(png_uf_pkg::FILT_PAETH),   '0},
    '{OP_FEED_SEEN,   2'b00, 12'h001,                       '{8'h01, 1'b1, 1'b1, 1'b0}},
    // Two rows of three single-byte pixels, Paeth on both: second row sees all neighbours
    '{OP_WRITE, png_uf_pkg::CFG_BYTES_PER_PIXEL, 12'd1, '0},
    '{OP_WRITE, png_uf_pkg::CFG_ROW_BYTES,       12'd3, '0},
    '{OP_WRITE, png_uf_pkg::CFG_IMAGE_ROWS,      12'd2, '0},
    '{OP_FEED, 2'b00, 12'(png_uf_pkg::FILT_PAETH),   '0},
    '{OP_FEED, 2'b00, 12'h0FF,                       '0},
    '{OP_FEED, 2'b00, 12'h002,                       '0},
    '{OP_FEED, 2'b00, 12'h080,                       '0},
    '{OP_FEED, 2'b00, 12'(png_uf_pkg::FILT_PAETH),   '0},
    '{OP_FEED, 2'b00, 12'h07F,                       '0},
    '{OP_FEED, 2'b00, 12'h0FE,                       '0},
    '{OP_FEED, 2'b00, 12'h001,                       '0},
    // Two-byte pixels, Average then Up; the image is left open for the random part
    '{OP_WRITE, png_uf_pkg::CFG_BYTES_PER_PIXEL, 12'd2, '0},
    '{OP_WRITE, png_uf_pkg::CFG_IMAGE_ROWS,      12'd3, '0},
    '{OP_FEED, 2'b00, 12'(png_uf_pkg::FILT_AVERAGE), '0},
    '{OP_FEED, 2'b00, 12'h0FF,                       '0},
    '{OP_FEED, 2'b00, 12'h0FF,                       '0},
    '{OP_FEED, 2'b00, 12'h0FF,                       '0},
    '{OP_FEED, 2'b00, 12'(png_uf_pkg::FILT_UP),      '0},
    '{OP_FEED, 2'b00, 12'h000,                       '0},
    '{OP_FEED, 2'b00, 12'h0FF,                       '0}
  };

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = 8'h00;   // [7:0] raw_byte
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [7:0]  m_tdata;             // [7:0] pixel_byte
  logic        m_tlast;             // row_last
  logic [1:0]  m_tuser;             // [0] image_last, [1] bad_filter
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = png_uf_pkg::CFG_BYTES_PER_PIXEL;
  logic [11:0] cfg_wdata = 12'd0;

  // Predictor state, mirrored from the block
  logic [7:0]  line_mem     [0:LINE_MAX-1];
  bit          line_written [0:LINE_MAX-1];
  logic [31:0] left_q       = '0;
  logic [31:0] upleft_q     = '0;
  logic [11:0] col_cnt      = '0;
  logic [9:0]  row_cnt      = '0;
  logic [2:0]  filt_kind    = png_uf_pkg::FILT_NONE;
  bit          want_filter  = 1'b1;
  bit          stopped      = 1'b0;
  logic [2:0]  cfg_bpp      = 3'd4;
  logic [11:0] cfg_len      = 12'd1;
  logic [9:0]  cfg_rows     = 10'd1;

  px_result_t  pixel_q [$];         // results still owed by the block
  int          mismatch_count = 0;
  int          quiet_cycles   = 0;
  int          burst_left     = 0;
  int          random_fed     = 0;
  bit          hold_request   = 1'b0;

  png_scanline_unfilter_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Out-of-range register values are clamped onto the legal span, 1 to hi
  function automatic int clamp_to(input int v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [7:0] paeth_choose(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
    int p;
    int da;
    int db;
    int dc;
    p  = int'(a) + int'(b) - int'(c);
    da = (p >= int'(a)) ? p - int'(a) : int'(a) - p;
    db = (p >= int'(b)) ? p - int'(b) : int'(b) - p;
    dc = (p >= int'(c)) ? p - int'(c) : int'(c) - p;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  // Advance the mirrored state by one accepted byte; returns 1 when a result is owed
  function automatic bit unfilter_step(input logic [7:0] raw, output px_result_t res);
    int         bpp;
    int         len;
    int         rows;
    int         shift;
    logic [10:0] col;
    logic [8:0] sum;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] v;
    bit         first_row;
    bit         has_left;
    bit         end_row;
    bit         end_img;
    res = '0;
    if (stopped) return 1'b0;

    if (want_filter) begin
      if (raw > {5'd0, png_uf_pkg::FILT_PAETH}) begin
        stopped = 1'b1;
        res.bad = 1'b1;
        return 1'b1;
      end
      filt_kind   = raw[2:0];
      want_filter = 1'b0;
      col_cnt     = '0;
      left_q      = '0;
      upleft_q    = '0;
      return 1'b0;
    end

    bpp       = clamp_to(int'(cfg_bpp), 4);
    len       = clamp_to(int'(cfg_len), LINE_MAX);
    rows      = clamp_to(int'(cfg_rows), ROWS_MAX);
    col       = col_cnt[10:0];
    first_row = (row_cnt == '0);
    has_left  = (int'(col_cnt) >= bpp);
    shift     = 8 * (bpp - 1);

    a = has_left ? 8'(left_q >> shift) : 8'h00;
    b = first_row ? 8'h00 : line_mem[col];
    c = (has_left && !first_row) ? 8'(upleft_q >> shift) : 8'h00;

    case (filt_kind)
      png_uf_pkg::FILT_SUB:     v = raw + a;
      png_uf_pkg::FILT_UP:      v = raw + b;
      png_uf_pkg::FILT_AVERAGE: begin
        sum = {1'b0, a} + {1'b0, b};
        v   = raw + sum[8:1];
      end
      png_uf_pkg::FILT_PAETH:   v = raw + paeth_choose(a, b, c);
      default:                  v = raw;
    endcase

    line_mem[col]     = v;
    line_written[col] = 1'b1;
    left_q            = {left_q[23:0], v};
    upleft_q          = {upleft_q[23:0], b};

    end_row = (int'(col_cnt) + 1 >= len);
    end_img = end_row && (int'(row_cnt) + 1 >= rows);
    if (end_row) begin
      want_filter = 1'b1;
      col_cnt     = '0;
      row_cnt     = end_img ? 10'd0 : row_cnt + 10'd1;
    end else begin
      col_cnt = col_cnt + 12'd1;
    end

    res = '{v, end_row, end_img, 1'b0};
    return 1'b1;
  endfunction

  // A longer row must never make the block read a line store entry that no row has written
  function automatic bit store_covers(input logic [11:0] len_val);
    int n;
    n = clamp_to(int'(len_val), LINE_MAX);
    for (int i = 0; i < n; i++) begin
      if (!line_written[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Offer one byte in the current burst, hold until the transfer, then predict
  task automatic feed_byte(input logic [7:0] raw, output bit got, output px_result_t res);
    int gap;
    if (cfg_we) cfg_we <= 1'b0;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : $urandom_range(0, 3);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= raw;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    got = unfilter_step(raw, res);
  endtask

  // Filter bytes land where the predictor expects one, data everywhere else
  task automatic feed_random();
    logic [7:0] raw;
    bit         got;
    px_result_t res;
    if (want_filter) begin
      raw = 8'($urandom_range(png_uf_pkg::FILT_NONE, png_uf_pkg::FILT_PAETH));
    end else begin
      case ($urandom_range(0, 7))
        0:       raw = 8'h00;
        1:       raw = 8'hFF;
        default: raw = 8'($urandom);
      endcase
    end
    feed_byte(raw, got, res);
    if (got) pixel_q.push_back(res);
    random_fed++;
    if (random_fed == RANDOM_ITEMS / 2) hold_request = 1'b1;
  endtask

  // Drop valid, drain every owed result, then let the pipe settle
  task automatic quiesce();
    s_tvalid  <= 1'b0;
    burst_left = 0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      png_uf_pkg::CFG_BYTES_PER_PIXEL: cfg_bpp  = val[2:0];
      png_uf_pkg::CFG_ROW_BYTES:       cfg_len  = val;
      png_uf_pkg::CFG_IMAGE_ROWS:      cfg_rows = val[9:0];
      default: ;
    endcase
  endtask

  // Receiver pacing: free-running, sparse, comb and coin-toss stretches, plus long hold-offs
  // on request so the queue fills and s_tready drops
  initial begin : rx_pacing
    int mode;
    int span;
    wait (rst == 1'b0);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        mode         = RX_HOLD;
        span         = HOLD_CYCLES;
      end else begin
        mode = $urandom_range(RX_FREE, RX_COIN);
        span = $urandom_range(8, 150);
      end
      for (int k = 0; k < span; k++) begin
        @(posedge clk);
        case (mode)
          RX_FREE:   m_tready <= 1'b1;
          RX_SPARSE: m_tready <= ($urandom_range(0, 4) == 0);
          RX_COMB:   m_tready <= (k % 4 != 3);
          RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
          default:   m_tready <= 1'b0;
        endcase
      end
    end
  end

  // Check every result transfer against the oldest owed result
  always @(posedge clk) begin : result_check
    px_result_t seen;
    px_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      seen = {m_tdata, m_tlast, m_tuser[0], m_tuser[1]};
      if (pixel_q.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected transfer: pixel %02h row_last %0b image_last %0b bad_filter %0b",
                   seen.pixel, seen.row_end, seen.img_end, seen.bad);
        mismatch_count++;
      end else begin
        want = pixel_q.pop_front();
        if (seen.pixel !== want.pixel || seen.row_end !== want.row_end ||
            seen.img_end !== want.img_end || seen.bad !== want.bad) begin
          if (mismatch_count < 10)
            $display("mismatch (pixel/row_last/image_last/bad_filter): expected %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b",
                     want.pixel, want.row_end, want.img_end, want.bad,
                     seen.pixel, seen.row_end, seen.img_end, seen.bad);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: too long without any transfer on either side ends the run
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    bit          got;
    px_result_t  res;
    int          phase_no;
    int          count;
    logic [11:0] new_bpp;
    logic [11:0] new_len;
    logic [11:0] new_rows;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    for (int i = 0; i < PLAN_LEN; i++) begin
      case (PLAN[i].op)
        OP_WRITE: begin
          if (!cfg_we) quiesce();
          write_reg(PLAN[i].reg_sel, PLAN[i].value);
        end
        OP_FEED_SEEN: begin
          feed_byte(PLAN[i].value[7:0], got, res);
          pixel_q.push_back(PLAN[i].want);
        end
        OP_FEED_SILENT: feed_byte(PLAN[i].value[7:0], got, res);
        default: begin
          feed_byte(PLAN[i].value[7:0], got, res);
          if (got) pixel_q.push_back(res);
        end
      endcase
    end

    // Random phases; each switch of settings may land mid-row or mid-image. One phase writes a
    // bytes-per-pixel value above its range, another writes zero to every register.
    hold_request = 1'b1;
    phase_no     = 0;
    while (random_fed < RANDOM_ITEMS || phase_no < 6) begin
      case (phase_no)
        2: begin
          new_bpp  = 12'd7;
          new_len  = 12'd48;
          new_rows = 12'd2;
          count    = 2 * 49;
        end
        4: begin
          new_bpp  = 12'd0;
          new_len  = 12'd0;
          new_rows = 12'd0;
          count    = 40;
        end
        default: begin
          new_bpp  = 12'($urandom_range(0, 7));
          new_len  = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 40))
                                                 : 12'($urandom_range(1, 10));
          new_rows = 12'($urandom_range(0, 5));
          count    = $urandom_range(20, 120);
        end
      endcase
      // Finish the image first if a longer row would reach unwritten line store entries
      if (!(row_cnt == '0 || store_covers(new_len))) begin
        while (!(want_filter && row_cnt == '0)) feed_random();
      end
      quiesce();
      write_reg(png_uf_pkg::CFG_BYTES_PER_PIXEL, new_bpp);
      write_reg(png_uf_pkg::CFG_ROW_BYTES, new_len);
      write_reg(png_uf_pkg::CFG_IMAGE_ROWS, new_rows);
      repeat (count) feed_random();
      phase_no++;
    end

    // Close the row, then a filter type just past Paeth: one error result, then silence
    while (!want_filter) feed_random();
    feed_byte(8'h05, got, res);
    pixel_q.push_back('{8'h00, 1'b0, 1'b0, 1'b1});
    repeat (2) begin
      feed_byte(8'($urandom), got, res);
      if (got) pixel_q.push_back(res);
    end

    quiesce();
    if (mismatch_count == 0 && pixel_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
